[src/mbe_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time unit.
package mbe_pkg;

  // Input word: one pixel coordinate, signed Q4.28.
  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
  } in_word_t;

  // Result word: escape step index and final orbit point, signed Q16.32.
  typedef struct packed {
    logic        [15:0] iteration_count;
    logic signed [47:0] final_re;
    logic signed [47:0] final_im;
  } out_word_t;

  // Configuration register indexes
  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_BAILOUT  = 1'b1;

  // Configuration reset values
  localparam logic [15:0] MAX_ITER_RESET = 16'd256;
  localparam logic [23:0] BAILOUT_RESET  = 24'd4096;

  // Orbit value limits
  localparam logic signed [47:0] ORBIT_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] ORBIT_MIN = 48'sh8000_0000_0000;

endpackage

[src/mandelbrot_escape_time.sv]
// Mandelbrot escape-time unit: shared 24x24 multiplier under a step sequencer.
//
//   channel  ports                          direction  handshake
//   input    start, busy, in_word           in         taken when start && !busy
//   result   out_strobe, out_word           out        one-cycle strobe, no stall
//   config   cfg_we, cfg_index, cfg_data    in         written when cfg_we
//
// Each orbit step runs three 48x48 products, each four 24x24 partials through the one
// multiplier and its output register, plus scale, update, load and escape-check states.
// The result strobe is high in the first cycle that busy is low. Reset (rst_n,
// synchronous) restores max_iterations 256 and bailout_norm 4096. The receiver cannot stall.
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 28,
  parameter int ORBIT_FRAC_BITS = 32,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // input word
  input  logic       start,
  output logic       busy,
  input  in_word_t   in_word,
  // result word
  output logic       out_strobe,
  output out_word_t  out_word,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [23:0] cfg_data
);

  // Coordinate alignment shifts (one of the two is zero)
  localparam int ALIGN = ORBIT_FRAC_BITS - COORD_FRAC_BITS;
  localparam int LSH   = (ALIGN > 0) ? ALIGN : 0;
  localparam int RSH   = (ALIGN < 0) ? -ALIGN : 0;
  // Counter compare width and escape compare width
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int LIM_W = (2 * ORBIT_FRAC_BITS + 24 > 97) ? 2 * ORBIT_FRAC_BITS + 24 : 97;
  localparam logic [2:0] PH_LAST = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOP, S_MUL, S_SCALE, S_UPDATE, S_LDRR, S_SQRE, S_CHECK
  } state_t;

  typedef enum logic [1:0] {
    OP_RI, OP_RR, OP_II
  } op_t;

  // Saturate a 64-bit signed value to the 48-bit orbit range
  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    logic hi_same;
    hi_same = (&v[63:47]) || !(|v[63:47]);
    if (hi_same) return v[47:0];
    return v[63] ? ORBIT_MIN : ORBIT_MAX;
  endfunction

  // Q4.28 coordinate to orbit format, floor on right shift
  function automatic logic signed [47:0] to_orbit(logic signed [31:0] v);
    logic signed [63:0] w;
    w = {{32{v[31]}}, v};
    w = (w <<< LSH) >>> RSH;
    return sat48(w);
  endfunction

  function automatic logic [47:0] mag48(logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [63:0] ext64(logic signed [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  // Control registers
  state_t                   state_r;
  op_t                      op_r;
  logic [2:0]               phase_r;
  logic [COUNT_WIDTH-1:0]   cnt_r;
  logic [15:0]              max_iter_r;
  logic [23:0]              bailout_r;
  logic                     out_strobe_r;
  out_word_t                out_word_r;

  // Datapath registers
  logic signed [47:0] c_re_r, c_im_r;
  logic signed [47:0] z_re_r, z_im_r;
  logic        [95:0] sq_re_r, sq_im_r;
  logic        [95:0] acc_r;
  logic        [47:0] prod_r;
  logic        [1:0]  prod_sh_r;
  logic        [47:0] mag_a_r, mag_b_r;
  logic               neg_r;
  logic signed [47:0] rr_r, ii_r, ri2_r;

  // Combinational values
  logic                   accept;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [CMP_W-1:0]       cnt_ext, cnt_nxt_ext, max_ext;
  logic [23:0]            a_half, b_half;
  logic [47:0]            prod_nxt;
  logic [95:0]            acc_add;
  logic [96:0]            norm;
  logic [LIM_W-1:0]       norm_ext, lim_ext;
  logic                   escape;
  logic [95:0]            rr_shift, ii_shift;
  logic signed [96:0]     ri_signed, ri_shift;
  logic signed [47:0]     rr_sat, ii_sat, ri2_sat;
  logic signed [63:0]     re_sum, im_sum;

  assign accept = start && (state_r == S_IDLE);

  // Step counter and loop bound
  always_comb begin
    cnt_nxt     = COUNT_WIDTH'(cnt_r + 1'b1);
    cnt_ext     = CMP_W'(cnt_r);
    cnt_nxt_ext = CMP_W'(cnt_nxt);
    max_ext     = CMP_W'(max_iter_r);
  end

  // Shared multiplier: one 24x24 partial per cycle, then shifted accumulate
  always_comb begin
    a_half   = phase_r[1] ? mag_a_r[47:24] : mag_a_r[23:0];
    b_half   = phase_r[0] ? mag_b_r[47:24] : mag_b_r[23:0];
    prod_nxt = {24'b0, a_half} * {24'b0, b_half};
    case (prod_sh_r)
      2'd0:    acc_add = {48'b0, prod_r};
      2'd1:    acc_add = {24'b0, prod_r, 24'b0};
      default: acc_add = {prod_r, 48'b0};
    endcase
  end

  // Escape test: exact |z|^2 against bailout scaled to orbit format
  always_comb begin
    norm     = {1'b0, sq_re_r} + {1'b0, acc_r};
    norm_ext = LIM_W'(norm);
    lim_ext  = LIM_W'(bailout_r) << (2 * ORBIT_FRAC_BITS);
    escape   = norm_ext > lim_ext;
  end

  // Scaling of squares and cross product, floor then saturate
  always_comb begin
    rr_shift  = sq_re_r >> ORBIT_FRAC_BITS;
    ii_shift  = sq_im_r >> ORBIT_FRAC_BITS;
    rr_sat    = (|rr_shift[95:47]) ? ORBIT_MAX : rr_shift[47:0];
    ii_sat    = (|ii_shift[95:47]) ? ORBIT_MAX : ii_shift[47:0];
    ri_signed = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    ri_shift  = ri_signed >>> (ORBIT_FRAC_BITS - 1);
    if ((&ri_shift[96:47]) || !(|ri_shift[96:47])) begin
      ri2_sat = ri_shift[47:0];
    end else begin
      ri2_sat = ri_shift[96] ? ORBIT_MIN : ORBIT_MAX;
    end
  end

  // New orbit point sums
  always_comb begin
    re_sum = ext64(rr_r) - ext64(ii_r) + ext64(c_re_r);
    im_sum = ext64(ri2_r) + ext64(c_im_r);
  end

  // Sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_RI;
      phase_r      <= '0;
      cnt_r        <= '0;
      max_iter_r   <= MAX_ITER_RESET;
      bailout_r    <= BAILOUT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_ITER: max_iter_r <= cfg_data[15:0];
          CFG_BAILOUT:  bailout_r  <= cfg_data;
          default:      ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_r   <= '0;
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (cnt_ext < max_ext) begin
            op_r    <= OP_RI;
            phase_r <= '0;
            state_r <= S_MUL;
          end else begin
            out_word_r.iteration_count <= cnt_ext[15:0];
            out_word_r.final_re        <= z_re_r;
            out_word_r.final_im        <= z_im_r;
            out_strobe_r               <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end
        S_MUL: begin
          if (phase_r == PH_LAST) begin
            phase_r <= '0;
            unique case (op_r)
              OP_RI:   state_r <= S_SCALE;
              OP_RR:   state_r <= S_SQRE;
              OP_II:   state_r <= S_CHECK;
              default: state_r <= S_CHECK;
            endcase
          end else begin
            phase_r <= phase_r + 3'd1;
          end
        end
        S_SCALE:  state_r <= S_UPDATE;
        S_UPDATE: state_r <= S_LDRR;
        S_LDRR: begin
          op_r    <= OP_RR;
          state_r <= S_MUL;
        end
        S_SQRE: begin
          op_r    <= OP_II;
          state_r <= S_MUL;
        end
        S_CHECK: begin
          if (escape || !(cnt_nxt_ext < max_ext)) begin
            out_word_r.iteration_count <= escape ? cnt_ext[15:0] : cnt_nxt_ext[15:0];
            out_word_r.final_re        <= z_re_r;
            out_word_r.final_im        <= z_im_r;
            out_strobe_r               <= 1'b1;
            if (!escape) cnt_r <= cnt_nxt;
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_nxt;
            op_r    <= OP_RI;
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          c_re_r  <= to_orbit(in_word.c_re);
          c_im_r  <= to_orbit(in_word.c_im);
          z_re_r  <= '0;
          z_im_r  <= '0;
          sq_re_r <= '0;
          sq_im_r <= '0;
        end
      end
      S_LOOP, S_CHECK: begin
        // operands for the cross product of the next step
        if (state_r == S_CHECK) sq_im_r <= acc_r;
        mag_a_r <= mag48(z_re_r);
        mag_b_r <= mag48(z_im_r);
        neg_r   <= z_re_r[47] ^ z_im_r[47];
      end
      S_MUL: begin
        if (phase_r != PH_LAST) begin
          prod_r    <= prod_nxt;
          prod_sh_r <= {1'b0, phase_r[1]} + {1'b0, phase_r[0]};
        end
        if (phase_r == 3'd0) acc_r <= '0;
        else acc_r <= acc_r + acc_add;
      end
      S_SCALE: begin
        rr_r  <= rr_sat;
        ii_r  <= ii_sat;
        ri2_r <= ri2_sat;
      end
      S_UPDATE: begin
        z_re_r <= sat48(re_sum);
        z_im_r <= sat48(im_sum);
      end
      S_LDRR: begin
        mag_a_r <= mag48(z_re_r);
        mag_b_r <= mag48(z_re_r);
      end
      S_SQRE: begin
        sq_re_r <= acc_r;
        mag_a_r <= mag48(z_im_r);
        mag_b_r <= mag48(z_im_r);
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

[verif/mandelbrot_escape_time_test.sv]
// Self-checking testbench for the Mandelbrot escape-time unit: directed and random pixel words.
module mandelbrot_escape_time_test
  import mbe_pkg::*;
();

  localparam int COORD_FRAC    = 28;
  localparam int ORBIT_FRAC    = 32;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 40;
  localparam int SETTLE_CYCLES = 40;

  localparam logic signed [31:0] COORD_ONE = 32'sh1000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  in_word_t    coord_word = '0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_MAX_ITER;
  logic [23:0] cfg_data   = '0;
  logic        busy;
  logic        out_strobe;
  out_word_t   result_word;

  // shadow copy of the configuration registers
  logic [15:0] max_iter_cfg = MAX_ITER_RESET;
  logic [23:0] bailout_cfg  = BAILOUT_RESET;

  out_word_t expected_escapes[$];
  int        mismatch_count = 0;
  bit        steady = 1'b0;

  always #5 clk = ~clk;

  mandelbrot_escape_time dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (coord_word),
    .out_strobe (out_strobe),
    .out_word   (result_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------- prediction

  function automatic logic signed [47:0] clamp48(input logic signed [127:0] v);
    if (v > 128'(ORBIT_MAX)) return ORBIT_MAX;
    if (v < 128'(ORBIT_MIN)) return ORBIT_MIN;
    return v[47:0];
  endfunction

  // floor(a*b / 2^shift), saturated
  function automatic logic signed [47:0] scaled_mul(input logic signed [47:0] a,
                                                   input logic signed [47:0] b,
                                                   input int shift);
    logic signed [127:0] wa, wb, p;
    wa = 128'(a);
    wb = 128'(b);
    p  = (wa * wb) >>> shift;
    return clamp48(p);
  endfunction

  function automatic out_word_t predict_escape(input in_word_t w);
    logic signed [127:0] c_re_w, c_im_w, re_w, im_w, norm, limit;
    logic signed [47:0]  c_re, c_im, re, im, rr, ii, ri2;
    int unsigned         steps;
    out_word_t           r;
    c_re_w = 128'(w.c_re);
    c_im_w = 128'(w.c_im);
    c_re_w = c_re_w <<< (ORBIT_FRAC - COORD_FRAC);
    c_im_w = c_im_w <<< (ORBIT_FRAC - COORD_FRAC);
    c_re   = clamp48(c_re_w);
    c_im   = clamp48(c_im_w);
    limit  = {104'd0, bailout_cfg} << (2 * ORBIT_FRAC);
    re     = '0;
    im     = '0;
    steps  = 0;
    while (steps < 32'(max_iter_cfg)) begin
      rr   = scaled_mul(re, re, ORBIT_FRAC);
      ii   = scaled_mul(im, im, ORBIT_FRAC);
      ri2  = scaled_mul(re, im, ORBIT_FRAC - 1);
      re_w = 128'(rr);
      re_w = re_w - 128'(ii) + 128'(c_re);
      im_w = 128'(ri2);
      im_w = im_w + 128'(c_im);
      re   = clamp48(re_w);
      im   = clamp48(im_w);
      // exact |z|^2 against bailout scaled to the orbit format
      re_w = 128'(re);
      im_w = 128'(im);
      norm = re_w * re_w + im_w * im_w;
      if (norm > limit) break;
      steps++;
    end
    r.iteration_count = steps[15:0];
    r.final_re        = re;
    r.final_im        = im;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_result
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (expected_escapes.size() == 0) begin
        $error("unexpected result word: iteration_count %0d", result_word.iteration_count);
        mismatch_count++;
      end else begin
        want = expected_escapes.pop_front();
        if (result_word.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d",
                 want.iteration_count, result_word.iteration_count);
          mismatch_count++;
        end
        if (result_word.final_re !== want.final_re) begin
          $error("final_re: expected %0d, got %0d",
                 $signed(want.final_re), $signed(result_word.final_re));
          mismatch_count++;
        end
        if (result_word.final_im !== want.final_im) begin
          $error("final_im: expected %0d, got %0d",
                 $signed(want.final_im), $signed(result_word.final_im));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // register write; ends with the enable low so it never toggles twice in one step
  task automatic write_reg(input logic idx, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CFG_MAX_ITER) max_iter_cfg = data[15:0];
    else bailout_cfg = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold start until the word is taken, then queue its prediction
  task automatic send_coord(input logic signed [31:0] re, input logic signed [31:0] im);
    in_word_t w;
    w.c_re = re;
    w.c_im = im;
    start      <= 1'b1;
    coord_word <= w;
    do @(posedge clk); while (busy);
    expected_escapes.push_back(predict_escape(w));
  endtask

  function automatic int gap_cycles();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic idle_gap();
    int n;
    n = gap_cycles();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_escapes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- random values

  // mostly the interesting region around the set, some full range, some edges
  function automatic logic signed [31:0] pick_coord_part(input bit imag);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if (imag) return int'($urandom_range(0, 671088640)) - 335544320;
      return int'($urandom_range(0, 805306368)) - 603979776;
    end
    if (r < 85) return $urandom;
    case ($urandom_range(0, 6))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return 32'sh4000_0000;
      default: return 32'shc000_0000;
    endcase
  endfunction

  // |c_re| >= 4, so the orbit leaves within a few steps
  function automatic logic signed [31:0] far_coord_re();
    logic [31:0] v;
    v = $urandom;
    v[31:30] = v[31] ? 2'b10 : 2'b01;
    return v;
  endfunction

  function automatic logic [23:0] random_bailout();
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'd4;
      2:       return BAILOUT_RESET;
      3:       return 24'hff_ffff;
      4:       return 24'($urandom_range(1, 24'hff_ffff));
      default: return 24'($urandom_range(2, 64));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset values: 256 steps, bailout 4096; bounded orbits run to the cap
  task automatic test_reset_config();
    send_coord(32'sd0, 32'sd0);
    idle_gap();
    send_coord(-COORD_ONE, 32'sd0);
    idle_gap();
    send_coord(COORD_ONE / 4, 32'sd0);
    idle_gap();
    send_coord(-(2 * COORD_ONE), 32'sd0);
    idle_gap();
    send_coord(32'sd0, COORD_ONE);
    drain_results();
  endtask

  // coordinate extremes under the largest step cap, then saturation at max bailout
  task automatic test_coord_extremes();
    write_reg(CFG_MAX_ITER, 24'h00_ffff);
    write_reg(CFG_BAILOUT, BAILOUT_RESET);
    send_coord(COORD_MIN, COORD_MIN);
    idle_gap();
    send_coord(COORD_MAX, COORD_MAX);
    idle_gap();
    send_coord(COORD_MIN, COORD_MAX);
    idle_gap();
    send_coord(COORD_MAX, COORD_MIN);
    idle_gap();
    send_coord(COORD_MIN, 32'sd0);
    idle_gap();
    send_coord(32'sd0, COORD_MAX);
    idle_gap();
    send_coord(32'sh5555_5555, 32'shaaaa_aaaa);
    idle_gap();
    send_coord(32'shaaaa_aaaa, 32'sh5555_5555);
    drain_results();
    write_reg(CFG_BAILOUT, 24'hff_ffff);
    send_coord(COORD_MIN, 32'sd0);
    idle_gap();
    send_coord(COORD_MAX, COORD_MAX);
    drain_results();
  endtask

  // zero step cap: no step, count 0 and z 0
  task automatic test_zero_maximum();
    write_reg(CFG_MAX_ITER, 24'd0);
    write_reg(CFG_BAILOUT, BAILOUT_RESET);
    send_coord(32'sd0, 32'sd0);
    idle_gap();
    send_coord(COORD_MAX, COORD_MIN);
    idle_gap();
    send_coord(COORD_ONE, -COORD_ONE);
    drain_results();
  endtask

  // zero bailout: any nonzero z escapes, z stuck at 0 runs to the cap
  task automatic test_zero_bailout();
    write_reg(CFG_MAX_ITER, 24'd5);
    write_reg(CFG_BAILOUT, 24'd0);
    send_coord(32'sd0, 32'sd0);
    idle_gap();
    send_coord(32'sd1, 32'sd0);
    idle_gap();
    send_coord(32'sd0, -32'sd1);
    drain_results();
  endtask

  // |z|^2 exactly equal to bailout does not escape; upper data bits of the cap ignored
  task automatic test_bailout_edges();
    write_reg(CFG_MAX_ITER, 24'h5a_0001);
    write_reg(CFG_BAILOUT, 24'd1);
    send_coord(32'sd0, 32'sd0);
    idle_gap();
    send_coord(COORD_ONE, 32'sd0);
    drain_results();
    write_reg(CFG_MAX_ITER, 24'ha5_0008);
    send_coord(COORD_ONE, 32'sd0);
    drain_results();
  endtask

  // random phases: each picks a configuration, then sends words, with random gaps unless the phase is steady
  task automatic test_random_phases();
    int          words;
    logic [15:0] cap;
    logic [23:0] bail;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (p == 3) begin
        cap   = MAX_ITER_RESET;
        bail  = BAILOUT_RESET;
        words = 18;
      end else if (p == 7) begin
        cap   = 16'hffff;
        bail  = random_bailout();
        words = 18;
      end else begin
        cap   = 16'($urandom_range(1, 40));
        bail  = random_bailout();
        words = PHASE_WORDS;
      end
      write_reg(CFG_MAX_ITER, {8'($urandom), cap});
      write_reg(CFG_BAILOUT, bail);
      for (int i = 0; i < words; i++) begin
        if (p == 7) send_coord(far_coord_re(), $urandom);
        else send_coord(pick_coord_part(1'b0), pick_coord_part(1'b1));
        // now and then let the unit run dry before the next word
        if ($urandom_range(0, 24) == 0) drain_results();
        else idle_gap();
      end
      drain_results();
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_coord_extremes();
    test_zero_maximum();
    test_zero_bailout();
    test_bailout_edges();
    test_random_phases();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
src/mbe_pkg.sv
src/mandelbrot_escape_time.sv
verif/mandelbrot_escape_time_test.sv
